// File: src/pfs_pkg.sv
// Shared types and constants for the PCM frame to s16 converter.
// No dependencies; every other file of the block imports this package.
package pfs_pkg;

  // Widths of the beat fields and of the internal level word
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned PCM16_W  = 16;
  localparam int unsigned MONO_W   = 32;
  // A level is Q1.31 held one bit wider so that it can reach exactly +1
  localparam int unsigned LVL_W    = 33;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned FMT_W  = 3;

  // Register indexes (paddr[2])
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_STEREO = 1'b1;

  // Sample format codes
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_PCM8    = 3'd1;
  localparam logic [FMT_W-1:0] FMT_PCM16   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_PCM24   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_PCM32   = 3'd4;

  // Level of exactly +1 and -1
  localparam logic signed [LVL_W-1:0] LVL_ONE     = {2'b01, 31'b0};
  localparam logic signed [LVL_W-1:0] LVL_NEG_ONE = {2'b11, 31'b0};

  typedef logic signed [LVL_W-1:0] level_t;

endpackage

// File: src/pfs_if.sv
// Stream interfaces for frame beats in and converted beats out.
// Depends on pfs_pkg for field widths.
interface pfs_in_if import pfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] left_sample;
  logic [SAMPLE_W-1:0] right_sample;
  logic                silent;
  logic                end_of_packet;

  modport source (output valid, left_sample, right_sample, silent, end_of_packet,
                  input ready);
  modport sink   (input valid, left_sample, right_sample, silent, end_of_packet,
                  output ready);
endinterface

interface pfs_out_if import pfs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PCM16_W-1:0] left_pcm16;
  logic signed [PCM16_W-1:0] right_pcm16;
  logic signed [MONO_W-1:0]  mono_level;
  logic                      last_of_packet;

  modport source (output valid, left_pcm16, right_pcm16, mono_level, last_of_packet,
                  input ready);
  modport sink   (input valid, left_pcm16, right_pcm16, mono_level, last_of_packet,
                  output ready);
endinterface

// File: src/pcm_frame_to_s16_stereo_mono.sv
// Top level: PCM frame to s16 stereo and Q1.31 mono converter.
// Pipeline: an input beat is registered in the lane stage, then in the merge stage.
// Throughput: one frame per cycle unless the output stalls; both lanes and the merge
// run every cycle, and each stage holds its beat only while the next stage is stalled.
// Reset: asynchronous active-low; clears stage valids, format to float32, stereo on.
// Depends on pfs_pkg, pfs_if, pfs_lane and pfs_merge.
module pcm_frame_to_s16_stereo_mono import pfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfs_in_if.sink            frame_in,
  pfs_out_if.source         frame_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [FMT_W-1:0] fmt_q;
  logic             stereo_q;
  logic             v1_q, v2_q;
  logic             rdy1, rdy2;
  level_t           lvl_l_d, lvl_r_d, lvl_l_q, lvl_r_q;
  logic             last1_q, last2_q;
  logic [SAMPLE_W-1:0] right_word;
  logic signed [PCM16_W-1:0] l16_d, r16_d, l16_q, r16_q;
  logic signed [MONO_W-1:0]  mono_d, mono_q;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_FLOAT32;
      stereo_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FORMAT: fmt_q    <= pwdata[FMT_W-1:0];
        REG_STEREO: stereo_q <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FORMAT: prdata = {{(APB_DW-FMT_W){1'b0}}, fmt_q};
      REG_STEREO: prdata = {{(APB_DW-1){1'b0}}, stereo_q};
      default:    prdata = '0;
    endcase
  end

  // Lanes: mono source feeds the left word to the right lane
  assign right_word = stereo_q ? frame_in.right_sample : frame_in.left_sample;

  pfs_lane u_lane_l (
    .word_i (frame_in.left_sample),
    .fmt_i  (fmt_q),
    .zero_i (frame_in.silent),
    .level_o(lvl_l_d)
  );

  pfs_lane u_lane_r (
    .word_i (right_word),
    .fmt_i  (fmt_q),
    .zero_i (frame_in.silent),
    .level_o(lvl_r_d)
  );

  // Stage handshake: advance when the downstream slot is free
  assign rdy2 = !v2_q || frame_out.ready;
  assign rdy1 = !v1_q || rdy2;
  assign frame_in.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= frame_in.valid;
      if (rdy2) v2_q <= v1_q;
    end
  end

  // Lane stage payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && frame_in.valid) begin
      lvl_l_q <= lvl_l_d;
      lvl_r_q <= lvl_r_d;
      last1_q <= frame_in.end_of_packet;
    end
  end

  pfs_merge u_merge (
    .left_i       (lvl_l_q),
    .right_i      (lvl_r_q),
    .left_pcm16_o (l16_d),
    .right_pcm16_o(r16_d),
    .mono_o       (mono_d)
  );

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      l16_q   <= l16_d;
      r16_q   <= r16_d;
      mono_q  <= mono_d;
      last2_q <= last1_q;
    end
  end

  assign frame_out.valid          = v2_q;
  assign frame_out.left_pcm16     = l16_q;
  assign frame_out.right_pcm16    = r16_q;
  assign frame_out.mono_level     = mono_q;
  assign frame_out.last_of_packet = last2_q;

  // Lane stage keeps its beat while the output stage is stalled
  a_v1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q)
    else $error("lane stage beat dropped under stall");

  // Output stage keeps its beat until taken
  a_v2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !frame_out.ready |=> v2_q && $stable(mono_q))
    else $error("output beat changed under stall");

  // Normalized levels stay within +-1
  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (lvl_l_q <= LVL_ONE && lvl_l_q >= LVL_NEG_ONE &&
              lvl_r_q <= LVL_ONE && lvl_r_q >= LVL_NEG_ONE))
    else $error("lane level out of range");

  // Scaling by 32767 never reaches the s16 minimum
  a_s16_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (l16_q != 16'sh8000 && r16_q != 16'sh8000))
    else $error("s16 scaling produced -32768");

endmodule

// File: src/pfs_lane.sv
// One channel lane: normalizes a raw sample word to a Q1.31 level.
// Depends on pfs_pkg for format codes and the level type.
module pfs_lane import pfs_pkg::*; (
  input  logic [SAMPLE_W-1:0] word_i,
  input  logic [FMT_W-1:0]    fmt_i,
  input  logic                zero_i,
  output level_t              level_o
);

  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  shamt;
  logic [30:0] frac;
  logic [31:0] fmag;
  level_t      flevel;

  // Float32: truncate toward zero, clamp to +-1, NaN and denormals to zero
  always_comb begin
    ex    = word_i[30:23];
    man   = word_i[22:0];
    shamt = 8'd126 - ex;
    frac  = {1'b1, man, 7'b0};
    if (shamt >= 8'd31) begin
      fmag = '0;
    end else begin
      fmag = {1'b0, frac >> shamt[4:0]};
    end
    if (ex == 8'hFF && man != '0) begin
      flevel = '0;
    end else if (ex >= 8'd127) begin
      flevel = word_i[31] ? LVL_NEG_ONE : LVL_ONE;
    end else if (ex == 8'd0) begin
      flevel = '0;
    end else begin
      flevel = word_i[31] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
    end
  end

  // Select the level by format; silence forces zero
  always_comb begin
    level_o = '0;
    if (!zero_i) begin
      case (fmt_i)
        FMT_FLOAT32: level_o = flevel;
        FMT_PCM8:    level_o = $signed({~word_i[7], ~word_i[7], word_i[6:0], 24'b0});
        FMT_PCM16:   level_o = $signed({word_i[15], word_i[15:0], 16'b0});
        FMT_PCM24:   level_o = $signed({word_i[23], word_i[23:0], 8'b0});
        FMT_PCM32:   level_o = $signed({word_i[31], word_i});
        default:     level_o = '0;
      endcase
    end
  end

endmodule

// File: src/pfs_merge.sv
// Merge stage: scales both lane levels to s16 and forms the mono average.
// Depends on pfs_pkg for widths and the level type.
module pfs_merge import pfs_pkg::*; (
  input  level_t                    left_i,
  input  level_t                    right_i,
  output logic signed [PCM16_W-1:0] left_pcm16_o,
  output logic signed [PCM16_W-1:0] right_pcm16_o,
  output logic signed [MONO_W-1:0]  mono_o
);

  localparam int unsigned PW = LVL_W + 15;

  logic signed [PW-1:0] lx, rx, lp, rp, lb, rb;
  logic signed [LVL_W:0] sum, sumb;
  logic signed [LVL_W-1:0] avg;

  // Scale by 32767 with shift-subtract, then divide by 2^31 toward zero
  always_comb begin
    lx = PW'(left_i);
    rx = PW'(right_i);
    lp = (lx <<< 15) - lx;
    rp = (rx <<< 15) - rx;
    lb = lp + (lp[PW-1] ? PW'(32'h7FFF_FFFF) : '0);
    rb = rp + (rp[PW-1] ? PW'(32'h7FFF_FFFF) : '0);
    left_pcm16_o  = lb[46:31];
    right_pcm16_o = rb[46:31];
  end

  // Halve the sum toward zero and saturate the single overflow at +1
  always_comb begin
    sum  = (LVL_W+1)'(left_i) + (LVL_W+1)'(right_i);
    sumb = sum + ((LVL_W+1)'(sum[LVL_W]));
    avg  = sumb[LVL_W:1];
    if (!avg[LVL_W-1] && avg[LVL_W-2]) begin
      mono_o = 32'sh7FFF_FFFF;
    end else begin
      mono_o = avg[MONO_W-1:0];
    end
  end

endmodule

// File: dv/pcm_frame_to_s16_stereo_mono_tb.sv
// Self-checking testbench for the PCM frame to s16 stereo and mono converter.
// Drives frame beats and APB register writes, predicts every output beat and
// compares in order. Depends on pfs_pkg, pfs_if and the top level of the block.
module pcm_frame_to_s16_stereo_mono_tb;
  import pfs_pkg::*;

  // Format codes the package leaves unnamed, and source modes
  localparam logic [FMT_W-1:0] FMT_UNSUPPORTED = 3'd5;
  localparam logic [FMT_W-1:0] FMT_SPARE       = 3'd7;
  localparam logic             SRC_MONO        = 1'b0;
  localparam logic             SRC_STEREO      = 1'b1;

  localparam int  N_DIR           = 22;
  localparam int  N_PHASES        = 10;
  localparam int  ITEMS_PER_PHASE = 80;
  localparam int  HOLD_PHASE      = 3;
  localparam int  HOLD_CYCLES     = 300;
  localparam longint ONE_LEVEL    = 64'sd2147483648;
  localparam int  TIMEOUT_TU      = 4_000_000;

  typedef enum int { IDLE_NONE, IDLE_FULL, IDLE_SPARSE } idle_mode_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_word;
    logic [SAMPLE_W-1:0] right_word;
    logic                silent;
    logic                eop;
  } frame_t;

  typedef struct packed {
    logic signed [PCM16_W-1:0] left;
    logic signed [PCM16_W-1:0] right;
    logic signed [MONO_W-1:0]  mono;
    logic                      last;
  } pcm_beat_t;

  typedef struct packed {
    logic [FMT_W-1:0]          fmt;
    logic                      stereo;
    logic [SAMPLE_W-1:0]       lw;
    logic [SAMPLE_W-1:0]       rw;
    logic                      sil;
    logic                      eop;
    logic                      typed;
    logic signed [PCM16_W-1:0] el;
    logic signed [PCM16_W-1:0] er;
    logic signed [MONO_W-1:0]  em;
  } row_t;

  // Directed frames; rows with typed set carry their result, others use the predictor
  row_t dir_tab [N_DIR] = '{
    '{FMT_FLOAT32, SRC_STEREO, 32'h3F800000, 32'hBF800000, 1'b0, 1'b0, 1'b1,
      16'sd32767, -16'sd32767, 32'sh00000000},
    '{FMT_FLOAT32, SRC_STEREO, 32'h7F800000, 32'h7FC00000, 1'b0, 1'b0, 1'b1,
      16'sd32767, 16'sd0, 32'sh40000000},
    '{FMT_FLOAT32, SRC_STEREO, 32'h3F800000, 32'h3F800000, 1'b0, 1'b1, 1'b1,
      16'sd32767, 16'sd32767, 32'sh7FFFFFFF},
    '{FMT_FLOAT32, SRC_STEREO, 32'h80000000, 32'h00000001, 1'b0, 1'b0, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_FLOAT32, SRC_STEREO, 32'h3F000000, 32'hFF800000, 1'b0, 1'b0, 1'b1,
      16'sd16383, -16'sd32767, 32'shE0000000},
    '{FMT_FLOAT32, SRC_STEREO, 32'h3F800000, 32'hBF800000, 1'b1, 1'b1, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_FLOAT32, SRC_STEREO, 32'h3C000000, 32'hB3000000, 1'b0, 1'b0, 1'b0,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM8, SRC_STEREO, 32'h00000000, 32'h000000FF, 1'b0, 1'b0, 1'b1,
      -16'sd32767, 16'sd32511, 32'shFF800000},
    '{FMT_PCM8, SRC_STEREO, 32'hFFFFFF80, 32'h12345680, 1'b0, 1'b1, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM16, SRC_STEREO, 32'h00008000, 32'h00007FFF, 1'b0, 1'b0, 1'b1,
      -16'sd32767, 16'sd32766, 32'shFFFF8000},
    '{FMT_PCM16, SRC_STEREO, 32'hABCD1234, 32'h0000FFFF, 1'b0, 1'b0, 1'b0,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM24, SRC_STEREO, 32'h00800000, 32'h007FFFFF, 1'b0, 1'b0, 1'b1,
      -16'sd32767, 16'sd32766, 32'shFFFFFF80},
    '{FMT_PCM24, SRC_STEREO, 32'hFF000001, 32'h00FFFFFF, 1'b0, 1'b1, 1'b0,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM32, SRC_STEREO, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1,
      -16'sd32767, 16'sd32766, 32'sh00000000},
    '{FMT_PCM32, SRC_STEREO, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 1'b1,
      -16'sd32767, -16'sd32767, 32'sh80000000},
    '{FMT_PCM32, SRC_STEREO, 32'h00000001, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_UNSUPPORTED, SRC_STEREO, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_SPARE, SRC_STEREO, 32'h3F800000, 32'h00000080, 1'b0, 1'b1, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM32, SRC_MONO, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b1,
      -16'sd32767, -16'sd32767, 32'sh80000000},
    '{FMT_FLOAT32, SRC_MONO, 32'h3F800000, 32'h00000000, 1'b0, 1'b1, 1'b1,
      16'sd32767, 16'sd32767, 32'sh7FFFFFFF},
    '{FMT_PCM16, SRC_MONO, 32'h00007FFF, 32'h00008000, 1'b1, 1'b0, 1'b1,
      16'sd0, 16'sd0, 32'sh00000000},
    '{FMT_PCM8, SRC_MONO, 32'h000000C3, 32'h00000000, 1'b0, 1'b1, 1'b0,
      16'sd0, 16'sd0, 32'sh00000000}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pfs_in_if  frame_in_if ();
  pfs_out_if frame_out_if ();

  pcm_frame_to_s16_stereo_mono dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_in  (frame_in_if),
    .frame_out (frame_out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the block's registers, updated only while the block is idle
  logic [FMT_W-1:0] cur_fmt    = FMT_FLOAT32;
  logic             cur_stereo = SRC_STEREO;

  pcm_beat_t  pending_pcm [$];
  pcm_beat_t  head_pcm;
  idle_mode_e src_mode = IDLE_SPARSE;
  idle_mode_e snk_mode = IDLE_SPARSE;
  logic       hold_go  = 1'b0;
  logic       hold_off = 1'b0;
  int         mismatches   = 0;
  int         beats_seen   = 0;
  int         frames_sent  = 0;
  int         stall_cycles = 0;
  int         settings_run = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Normalize one raw sample word to a Q1.31 level that can reach +1
  function automatic longint level_of(logic [FMT_W-1:0] fmt, logic [SAMPLE_W-1:0] w);
    int     ex;
    int     sh;
    longint m;
    longint mag;
    case (fmt)
      FMT_FLOAT32: begin
        ex = int'(w[30:23]);
        if (ex == 255 && w[22:0] != 23'd0) return 0;
        if (ex >= 127) begin
          mag = ONE_LEVEL;
        end else if (ex == 0) begin
          mag = 0;
        end else begin
          m  = longint'({1'b1, w[22:0]});
          sh = ex - 119;
          if (sh >= 0) mag = m << sh;
          else if (-sh >= 24) mag = 0;
          else mag = m >> (-sh);
        end
        return w[31] ? -mag : mag;
      end
      FMT_PCM8:  return (longint'(w[7:0]) - 128) * 16777216;
      FMT_PCM16: return longint'($signed(w[15:0])) * 65536;
      FMT_PCM24: return longint'($signed(w[23:0])) * 256;
      FMT_PCM32: return longint'($signed(w));
      default:   return 0;
    endcase
  endfunction

  // Scale a level to s16, truncating toward zero
  function automatic logic signed [PCM16_W-1:0] level_to_pcm16(longint x);
    longint n;
    n = (x * 32767) / ONE_LEVEL;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n[PCM16_W-1:0];
  endfunction

  // Expected output beat for one frame under the mirrored settings
  function automatic pcm_beat_t convert_frame(frame_t f);
    longint    l;
    longint    r;
    longint    avg;
    pcm_beat_t b;
    l = 0;
    r = 0;
    if (!f.silent) begin
      l = level_of(cur_fmt, f.left_word);
      r = cur_stereo ? level_of(cur_fmt, f.right_word) : l;
    end
    avg = (l + r) / 2;
    if (avg > 64'sd2147483647) avg = 64'sd2147483647;
    b.left  = level_to_pcm16(l);
    b.right = level_to_pcm16(r);
    b.mono  = avg[MONO_W-1:0];
    b.last  = f.eop;
    return b;
  endfunction

  function automatic int draw_gap(idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 17);
      default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // Sample word mix: raw noise, float-like values near unity, edges, short words
  function automatic logic [SAMPLE_W-1:0] rand_word();
    logic [SAMPLE_W-1:0] edges [14] = '{
      32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7F800000,
      32'hFF800000, 32'h3F800000, 32'hBF800000, 32'h00000080, 32'h00008000,
      32'h00800000, 32'h0000007F, 32'h00007FFF, 32'h007FFFFF};
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom();
    if (sel < 6) return {1'($urandom_range(0, 1)), 8'($urandom_range(96, 130)),
                         23'($urandom())};
    if (sel == 6) return edges[$urandom_range(0, 13)];
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  // One APB transfer; the caller lowers psel after its last transfer
  task automatic apb_xfer(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic report(input string what, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  task automatic check_reg(input logic idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want) report(idx == REG_FORMAT ? "sample_format readback" :
                            "stereo_source readback", longint'(want), longint'(rd));
  endtask

  // Drain, wait out the pipeline, then write and read back both registers
  task automatic apply_config(input logic [FMT_W-1:0] fmt, input logic stereo);
    logic [APB_DW-1:0] rd;
    frame_in_if.valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_xfer(1'b1, REG_FORMAT, {29'($urandom()), fmt}, rd);
    apb_xfer(1'b1, REG_STEREO, {31'($urandom()), stereo}, rd);
    check_reg(REG_FORMAT, APB_DW'(fmt));
    check_reg(REG_STEREO, APB_DW'(stereo));
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_fmt    = fmt;
    cur_stereo = stereo;
    settings_run++;
  endtask

  // Offer one frame beat; keep valid high across back-to-back beats
  task automatic send_frame(input frame_t f, input logic typed, input pcm_beat_t want);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      frame_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frame_in_if.valid         <= 1'b1;
    frame_in_if.left_sample   <= f.left_word;
    frame_in_if.right_sample  <= f.right_word;
    frame_in_if.silent        <= f.silent;
    frame_in_if.end_of_packet <= f.eop;
    do @(posedge clk_i); while (frame_in_if.ready !== 1'b1);
    pending_pcm.push_back(typed ? want : convert_frame(f));
    frames_sent++;
  endtask

  // Receiver: random gap per beat, plus the long hold-off when requested
  initial begin : sink_proc
    int gap;
    frame_out_if.ready = 1'b0;
    forever begin
      gap = draw_gap(snk_mode);
      if (gap > 0 || hold_off) begin
        frame_out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      frame_out_if.ready <= 1'b1;
      do @(posedge clk_i); while (frame_out_if.valid !== 1'b1);
    end
  end

  // Hold the receiver off for a long stretch so the block backs up
  initial begin : hold_proc
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Compare every accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    if (frame_in_if.valid === 1'b1 && frame_in_if.ready !== 1'b1) stall_cycles++;
    if (rst_ni === 1'b1 && frame_out_if.valid === 1'b1 && frame_out_if.ready === 1'b1) begin
      beats_seen++;
      if (pending_pcm.size() == 0) begin
        report("beat with nothing pending, mono_level", 0,
               longint'(frame_out_if.mono_level));
      end else begin
        head_pcm = pending_pcm.pop_front();
        if (frame_out_if.left_pcm16 !== head_pcm.left)
          report("left_pcm16", head_pcm.left, frame_out_if.left_pcm16);
        if (frame_out_if.right_pcm16 !== head_pcm.right)
          report("right_pcm16", head_pcm.right, frame_out_if.right_pcm16);
        if (frame_out_if.mono_level !== head_pcm.mono)
          report("mono_level", head_pcm.mono, frame_out_if.mono_level);
        if (frame_out_if.last_of_packet !== head_pcm.last)
          report("last_of_packet", head_pcm.last, frame_out_if.last_of_packet);
      end
    end
  end

  initial begin : timeout_proc
    #(TIMEOUT_TU);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_proc
    frame_t     f;
    pcm_beat_t  want;
    logic [FMT_W-1:0] fmt;
    logic       stereo;
    frame_in_if.valid         = 1'b0;
    frame_in_if.left_sample   = '0;
    frame_in_if.right_sample  = '0;
    frame_in_if.silent        = 1'b0;
    frame_in_if.end_of_packet = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers must come out of reset as float32, stereo
    check_reg(REG_FORMAT, APB_DW'(FMT_FLOAT32));
    check_reg(REG_STEREO, APB_DW'(SRC_STEREO));
    psel    <= 1'b0;
    penable <= 1'b0;

    // Directed table; reconfigure whenever a row asks for other settings
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].fmt != cur_fmt || dir_tab[i].stereo != cur_stereo)
        apply_config(dir_tab[i].fmt, dir_tab[i].stereo);
      f    = '{dir_tab[i].lw, dir_tab[i].rw, dir_tab[i].sil, dir_tab[i].eop};
      want = '{dir_tab[i].el, dir_tab[i].er, dir_tab[i].em, dir_tab[i].eop};
      send_frame(f, dir_tab[i].typed, want);
    end

    // Random phases: one format per phase, random source mode and idling
    for (int p = 0; p < N_PHASES; p++) begin
      fmt    = (p < 8) ? FMT_W'(p) : FMT_FLOAT32;
      stereo = 1'($urandom_range(0, 1));
      apply_config(fmt, stereo);
      src_mode = idle_mode_e'($urandom_range(0, 2));
      snk_mode = idle_mode_e'($urandom_range(0, 2));
      if (p == HOLD_PHASE) begin
        src_mode = IDLE_NONE;
        hold_go  = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        f.left_word  = rand_word();
        f.right_word = rand_word();
        f.silent     = ($urandom_range(0, 7) == 0);
        f.eop        = ($urandom_range(0, 3) == 0);
        send_frame(f, 1'b0, '0);
      end
    end

    // Drop valid, drain, and give the pipeline time to show any extra beat
    frame_in_if.valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d frames under %0d register settings, %0d beats checked.",
             frames_sent, settings_run, beats_seen);
    $display("Input was stalled for %0d cycles; %0d mismatches found.",
             stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pfs_pkg.sv
src/pfs_if.sv
src/pfs_lane.sv
src/pfs_merge.sv
src/pcm_frame_to_s16_stereo_mono.sv
dv/pcm_frame_to_s16_stereo_mono_tb.sv
